>>> design/mlpbp_pkg.sv
// Shared types, constants and arithmetic helpers of the backpropagation trainer.
package mlpbp_pkg;

  localparam int INPUTS_DEF  = 35;
  localparam int HIDDEN_DEF  = 5;
  localparam int OUTPUTS_DEF = 10;

  localparam int PATTERN_W = 35;
  localparam int TARGET_W  = 10;
  localparam int ROW_W     = 6;
  localparam int COL_W     = 4;
  localparam int UNIT_W    = 4;
  localparam int ACT_W     = 16;
  localparam int ERR_W     = 19;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam int A_W    = 18;
  localparam int B_W    = 40;
  localparam int PROD_W = A_W + B_W;
  localparam int ACC_W  = 60;
  localparam int SQ_W   = 40;
  localparam int G_W    = 33;
  localparam int E_W    = 18;

  localparam int ERR_MAX = 524287;

  localparam logic [CFG_W-1:0] LR_RESET = 16'd32768;
  localparam logic [CFG_W-1:0] MG_RESET = 16'd6554;

  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOMENTUM_GAIN = 2'd1;

  localparam int SIG_SIZE = 1024;
  localparam int SIG_HALF = 512;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [15:0] w16_t;
  typedef logic [15:0] sig_tab_t [SIG_SIZE];

  localparam acc_t RND15 = acc_t'(1) <<< 15;
  localparam acc_t RND31 = acc_t'(1) <<< 31;
  localparam acc_t RND35 = acc_t'(1) <<< 35;

  typedef enum logic [1:0] {
    CMD_INFER = 2'd0,
    CMD_TRAIN = 2'd1,
    CMD_LOAD  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_LOAD = 9'b000000010,
    ST_FH   = 9'b000000100,
    ST_FO   = 9'b000001000,
    ST_EMIT = 9'b000010000,
    ST_GRAD = 9'b000100000,
    ST_HERR = 9'b001000000,
    ST_UO   = 9'b010000000,
    ST_UI   = 9'b100000000
  } state_e;

  // Clamp a wide signed value to the Q4.12 range.
  function automatic w16_t sat16(input acc_t v);
    w16_t r;
    if (v > acc_t'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -acc_t'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Unsigned 64-bit quotient by shift and subtract, used only to build the table.
  function automatic logic [63:0] udiv64(input logic [63:0] n_i, input logic [63:0] d_i);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n_i[b]};
      if (rem >= {1'b0, d_i}) begin
        rem    = rem - {1'b0, d_i};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sigmoid table, evaluated at elaboration with exact integer arithmetic.
  function automatic sig_tab_t build_sig_table();
    sig_tab_t    tab;
    logic [63:0] pw [SIG_HALF+1];
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] q;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] v;
    int          k;
    term = 64'd1 << 60;
    sum  = term;
    for (int n = 1; n <= 12; n++) begin
      term = udiv64(term, 64'd64 * 64'(n));
      if ((n & 1) != 0) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    q = (sum + (64'd1 << 28)) >> 29;
    pw[0] = 64'd1 << 31;
    for (int i = 1; i <= SIG_HALF; i++) begin
      pw[i] = (pw[i-1] * q + (64'd1 << 30)) >> 31;
    end
    for (int i = 0; i < SIG_SIZE; i++) begin
      k   = i - SIG_HALF;
      e   = pw[(k >= 0) ? k : -k];
      den = (64'd1 << 31) + e;
      num = (k >= 0) ? (64'd1 << 47) : (e << 16);
      v   = udiv64(num + (den >> 1), den);
      tab[i] = (v > 64'd65535) ? 16'hffff : v[15:0];
    end
    return tab;
  endfunction

endpackage

>>> design/mlp_backprop_momentum_trainer.sv
// Top level of the two-layer perceptron trainer with momentum.
//
// Usage: drive command_i and its payload fields and raise start while busy is
// low; the item is taken at that clock edge and busy rises on the next cycle.
// Load (command 2) writes one weight if its row and column are in range,
// clears its previous change and answers with a single acknowledge result
// (unit 0, activation 0, last set) registered in the load state. Infer (0)
// and train (1) run the forward pass and then present one result per output
// unit on consecutive cycles, each marked by result_valid_o for exactly one
// cycle; the last one carries the half squared error. The receiver cannot
// stall, so results must be sampled when they appear. Command 3 is dropped
// without a result. Train adds gradient, hidden error and weight updates
// after the results. All steps share one 18x40 multiplier and make at most
// one access to each weight memory per step.
// Reset clears all weights and previous changes through per-entry valid bits
// at once, so no clearing pass is needed; the registers return to 0.5 and
// 0.1. Configuration writes take effect at the write edge and belong between
// items.
module mlp_backprop_momentum_trainer import mlpbp_pkg::*; #(
  parameter int INPUTS       = INPUTS_DEF,
  parameter int HIDDEN_UNITS = HIDDEN_DEF,
  parameter int OUTPUTS      = OUTPUTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           command_i,
  input  logic [PATTERN_W-1:0] pattern_bits_i,
  input  logic [TARGET_W-1:0]  target_bits_i,
  input  logic                 weight_layer_i,
  input  logic [ROW_W-1:0]     weight_row_i,
  input  logic [COL_W-1:0]     weight_col_i,
  input  logic signed [15:0]   weight_value_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output logic                 result_valid_o,
  output logic [UNIT_W-1:0]    unit_index_o,
  output logic [ACT_W-1:0]     activation_o,
  output logic [ERR_W-1:0]     pattern_error_o,
  output logic                 last_o
);

  localparam int HW    = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
  localparam int OW    = (OUTPUTS > 1) ? $clog2(OUTPUTS) : 1;
  localparam int INW   = (INPUTS > 1) ? $clog2(INPUTS) : 1;
  localparam int MAX_I = (INPUTS > HIDDEN_UNITS) ? INPUTS : HIDDEN_UNITS;
  localparam int MAX_J = (OUTPUTS > HIDDEN_UNITS) ? OUTPUTS : HIDDEN_UNITS;
  localparam int CI_W  = (MAX_I > 1) ? $clog2(MAX_I) : 1;
  localparam int CJ_W  = (MAX_J > 1) ? $clog2(MAX_J) : 1;
  localparam int IH_D  = INPUTS * HIDDEN_UNITS;
  localparam int HO_D  = HIDDEN_UNITS * OUTPUTS;
  localparam int IH_AW = (IH_D > 1) ? $clog2(IH_D) : 1;
  localparam int HO_AW = (HO_D > 1) ? $clog2(HO_D) : 1;

  // Sequencer state.
  state_e            state_q, state_d;
  logic [2:0]        sub_q, sub_d;
  logic [CI_W-1:0]   i_q, i_d;
  logic [CJ_W-1:0]   j_q, j_d;
  acc_t              acc_q, acc_d;
  logic [SQ_W-1:0]   sumsq_q, sumsq_d;
  logic signed [B_W-1:0] tmp_q, tmp_d;
  logic [15:0]       p_q, p_d;
  w16_t              c_q, c_d;
  logic              pbit_q, pbit_d;

  // Latched item.
  cmd_e              cmd_q;
  logic [INPUTS-1:0] pat_q;
  logic [OUTPUTS-1:0] tgt_q;
  logic              ld_layer_q;
  logic [ROW_W-1:0]  ld_row_q;
  logic [COL_W-1:0]  ld_col_q;
  w16_t              ld_val_q;
  logic              latch_in;

  logic [CFG_W-1:0]  lr_q;
  logic [CFG_W-1:0]  mg_q;

  // Per-unit working values.
  logic [ACT_W-1:0]      hid_act_q [HIDDEN_UNITS];
  logic [ACT_W-1:0]      out_act_q [OUTPUTS];
  logic signed [E_W-1:0] e_q [OUTPUTS];
  logic signed [G_W-1:0] g_q [OUTPUTS];
  w16_t                  ch_q [HIDDEN_UNITS];
  logic                  hid_we, out_we, g_we, ch_we;
  logic [ACT_W-1:0]      out_wdata;
  logic signed [E_W-1:0] e_wdata;
  logic signed [G_W-1:0] g_wdata;
  w16_t                  ch_wdata;

  // Result register.
  logic              res_valid_q, res_valid_d;
  logic [UNIT_W-1:0] res_unit_q, res_unit_d;
  logic [ACT_W-1:0]  res_act_q, res_act_d;
  logic [ERR_W-1:0]  res_err_q, res_err_d;
  logic              res_last_q, res_last_d;

  // Memories and their valid bits.
  logic              ih_we, ih_re, ho_we, ho_re;
  logic [IH_AW-1:0]  ih_waddr, ih_raddr, ih_addr_cur;
  logic [HO_AW-1:0]  ho_waddr, ho_raddr, ho_addr_cur;
  logic [31:0]       ih_wdata, ho_wdata, ih_rdata, ho_rdata;
  logic [IH_D-1:0]   ih_vld_q;
  logic [HO_D-1:0]   ho_vld_q;
  logic              ih_vrd_q, ho_vrd_q;
  w16_t              ih_w, ih_prev, ho_w, ho_prev;

  // Shared units.
  logic signed [A_W-1:0]    mul_a;
  logic signed [B_W-1:0]    mul_b;
  logic signed [PROD_W-1:0] mul_p;
  w16_t                     sig_net;
  logic [ACT_W-1:0]         sig_act;

  // Convenience values.
  acc_t              prod_x, mom_v, acc_rnd;
  logic [SQ_W-1:0]   sq_rnd;
  logic [ERR_W-1:0]  perr;
  logic [ACT_W-1:0]  y_i, z_j;
  logic signed [E_W-1:0] e_j;
  logic signed [G_W-1:0] g_j;
  w16_t              ch_j, cx;
  logic              pat_i, tgt_j;
  logic              i_last_in, i_last_h, j_last_h, j_last_o;
  logic              ld_ok_ih, ld_ok_ho;
  logic [INPUTS+PATTERN_W-1:0] pat_ext;
  logic [OUTPUTS+TARGET_W-1:0] tgt_ext;

  assign pat_ext = {{INPUTS{1'b0}}, pattern_bits_i};
  assign tgt_ext = {{OUTPUTS{1'b0}}, target_bits_i};

  mlpbp_ram #(.WIDTH(32), .DEPTH(IH_D)) u_ih_ram (
    .clk_i   (clk_i),
    .we_i    (ih_we),
    .waddr_i (ih_waddr),
    .wdata_i (ih_wdata),
    .re_i    (ih_re),
    .raddr_i (ih_raddr),
    .rdata_o (ih_rdata)
  );

  mlpbp_ram #(.WIDTH(32), .DEPTH(HO_D)) u_ho_ram (
    .clk_i   (clk_i),
    .we_i    (ho_we),
    .waddr_i (ho_waddr),
    .wdata_i (ho_wdata),
    .re_i    (ho_re),
    .raddr_i (ho_raddr),
    .rdata_o (ho_rdata)
  );

  mlpbp_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  mlpbp_sig u_sig (
    .clk_i (clk_i),
    .net_i (sig_net),
    .act_o (sig_act)
  );

  // Entries never written since reset read as zero.
  assign ih_w    = ih_vrd_q ? ih_rdata[31:16] : 16'sd0;
  assign ih_prev = ih_vrd_q ? ih_rdata[15:0]  : 16'sd0;
  assign ho_w    = ho_vrd_q ? ho_rdata[31:16] : 16'sd0;
  assign ho_prev = ho_vrd_q ? ho_rdata[15:0]  : 16'sd0;

  assign ih_addr_cur = IH_AW'(int'(i_q) * HIDDEN_UNITS + int'(j_q));
  assign ho_addr_cur = HO_AW'(int'(i_q) * OUTPUTS + int'(j_q));

  assign y_i   = hid_act_q[i_q[HW-1:0]];
  assign z_j   = out_act_q[j_q[OW-1:0]];
  assign e_j   = e_q[j_q[OW-1:0]];
  assign g_j   = g_q[j_q[OW-1:0]];
  assign ch_j  = ch_q[j_q[HW-1:0]];
  assign pat_i = pat_q[i_q[INW-1:0]];
  assign tgt_j = tgt_q[j_q[OW-1:0]];
  assign cx    = pat_i ? ch_j : 16'sd0;

  assign i_last_in = (i_q == CI_W'(INPUTS - 1));
  assign i_last_h  = (i_q == CI_W'(HIDDEN_UNITS - 1));
  assign j_last_h  = (j_q == CJ_W'(HIDDEN_UNITS - 1));
  assign j_last_o  = (j_q == CJ_W'(OUTPUTS - 1));

  // Rounded forms shared by several steps: round(x, 16) is (x + 2^15) >>> 16.
  assign prod_x  = ACC_W'(mul_p);
  assign mom_v   = (prod_x + RND15) >>> 16;
  assign acc_rnd = (acc_q + RND15) >>> 16;

  assign sq_rnd = (sumsq_q + SQ_W'(65536)) >> 17;
  assign perr   = (sq_rnd > SQ_W'(ERR_MAX)) ? ERR_W'(ERR_MAX) : sq_rnd[ERR_W-1:0];

  assign ld_ok_ih = !ld_layer_q && (int'(ld_row_q) < INPUTS) &&
                    (int'(ld_col_q) < HIDDEN_UNITS);
  assign ld_ok_ho = ld_layer_q && (int'(ld_row_q) < HIDDEN_UNITS) &&
                    (int'(ld_col_q) < OUTPUTS);

  assign busy = (state_q != ST_IDLE);

  always_comb begin
    state_d  = state_q;
    sub_d    = sub_q;
    i_d      = i_q;
    j_d      = j_q;
    acc_d    = acc_q;
    sumsq_d  = sumsq_q;
    tmp_d    = tmp_q;
    p_d      = p_q;
    c_d      = c_q;
    pbit_d   = pbit_q;
    latch_in = 1'b0;

    mul_a   = '0;
    mul_b   = '0;
    sig_net = '0;

    ih_re    = 1'b0;
    ih_raddr = ih_addr_cur;
    ih_we    = 1'b0;
    ih_waddr = ih_addr_cur;
    ih_wdata = '0;
    ho_re    = 1'b0;
    ho_raddr = ho_addr_cur;
    ho_we    = 1'b0;
    ho_waddr = ho_addr_cur;
    ho_wdata = '0;

    hid_we    = 1'b0;
    out_we    = 1'b0;
    g_we      = 1'b0;
    ch_we     = 1'b0;
    out_wdata = sig_act;
    e_wdata   = $signed({2'b00, sig_act}) - (tgt_j ? 18'sd65536 : 18'sd0);
    g_wdata   = mul_p[G_W-1:0];
    ch_wdata  = sat16(-((prod_x + RND31) >>> 32));

    res_valid_d = 1'b0;
    res_unit_d  = res_unit_q;
    res_act_d   = res_act_q;
    res_err_d   = res_err_q;
    res_last_d  = res_last_q;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          latch_in = 1'b1;
          i_d      = '0;
          j_d      = '0;
          sub_d    = '0;
          acc_d    = '0;
          sumsq_d  = '0;
          case (cmd_e'(command_i))
            CMD_LOAD:  state_d = ST_LOAD;
            CMD_INFER: state_d = ST_FH;
            CMD_TRAIN: state_d = ST_FH;
            default:   state_d = ST_IDLE;
          endcase
        end
      end

      ST_LOAD: begin
        ih_waddr = IH_AW'(int'(ld_row_q) * HIDDEN_UNITS + int'(ld_col_q));
        ho_waddr = HO_AW'(int'(ld_row_q) * OUTPUTS + int'(ld_col_q));
        ih_wdata = {ld_val_q, 16'h0000};
        ho_wdata = {ld_val_q, 16'h0000};
        ih_we    = ld_ok_ih;
        ho_we    = ld_ok_ho;
        res_valid_d = 1'b1;
        res_unit_d  = '0;
        res_act_d   = '0;
        res_err_d   = '0;
        res_last_d  = 1'b1;
        state_d     = ST_IDLE;
      end

      // Hidden net inputs: one weight read per cycle, summed where the
      // pattern bit is set; each weight is added in the cycle after its read.
      ST_FH: begin
        case (sub_q)
          3'd0: begin
            ih_re  = 1'b1;
            pbit_d = pat_i;
            if (i_q != '0) begin
              acc_d = acc_q + ACC_W'(pbit_q ? ih_w : 16'sd0);
            end
            if (i_last_in) begin
              sub_d = 3'd1;
            end else begin
              i_d = i_q + 1'b1;
            end
          end
          3'd1: begin
            acc_d = acc_q + ACC_W'(pbit_q ? ih_w : 16'sd0);
            sub_d = 3'd2;
          end
          3'd2: begin
            sig_net = sat16(acc_q);
            sub_d   = 3'd3;
          end
          default: begin
            hid_we = 1'b1;
            acc_d  = '0;
            i_d    = '0;
            sub_d  = 3'd0;
            if (j_last_h) begin
              j_d     = '0;
              state_d = ST_FO;
            end else begin
              j_d = j_q + 1'b1;
            end
          end
        endcase
      end

      // Output units: weighted sum of hidden activations, sigmoid, error
      // and its square into the running sum.
      ST_FO: begin
        case (sub_q)
          3'd0: begin
            ho_re = 1'b1;
            sub_d = 3'd1;
          end
          3'd1: begin
            mul_a = A_W'(ho_w);
            mul_b = B_W'({1'b0, y_i});
            sub_d = 3'd2;
          end
          3'd2: begin
            acc_d = acc_q + prod_x;
            if (i_last_h) begin
              sub_d = 3'd3;
            end else begin
              i_d   = i_q + 1'b1;
              sub_d = 3'd0;
            end
          end
          3'd3: begin
            sig_net = sat16(acc_rnd);
            sub_d   = 3'd4;
          end
          3'd4: begin
            out_we = 1'b1;
            mul_a  = e_wdata;
            mul_b  = B_W'(e_wdata);
            sub_d  = 3'd5;
          end
          default: begin
            sumsq_d = sumsq_q + mul_p[SQ_W-1:0];
            acc_d   = '0;
            i_d     = '0;
            sub_d   = 3'd0;
            if (j_last_o) begin
              j_d     = '0;
              state_d = ST_EMIT;
            end else begin
              j_d = j_q + 1'b1;
            end
          end
        endcase
      end

      ST_EMIT: begin
        res_valid_d = 1'b1;
        res_unit_d  = UNIT_W'(j_q);
        res_act_d   = z_j;
        res_err_d   = j_last_o ? perr : '0;
        res_last_d  = j_last_o;
        if (j_last_o) begin
          j_d   = '0;
          sub_d = 3'd0;
          state_d = (cmd_q == CMD_TRAIN) ? ST_GRAD : ST_IDLE;
        end else begin
          j_d = j_q + 1'b1;
        end
      end

      // Output gradients g = ((z(1-z)) >> 16) * e.
      ST_GRAD: begin
        case (sub_q)
          3'd0: begin
            mul_a = A_W'({1'b0, z_j});
            mul_b = B_W'(17'h10000 - {1'b0, z_j});
            sub_d = 3'd1;
          end
          3'd1: begin
            mul_a = A_W'({1'b0, mul_p[31:16]});
            mul_b = B_W'(e_j);
            sub_d = 3'd2;
          end
          default: begin
            g_we  = 1'b1;
            sub_d = 3'd0;
            if (j_last_o) begin
              j_d     = '0;
              i_d     = '0;
              acc_d   = '0;
              state_d = ST_HERR;
            end else begin
              j_d = j_q + 1'b1;
            end
          end
        endcase
      end

      // Hidden deltas from the old output weights, then each hidden unit's
      // input weight change, which is the same for every set input bit.
      ST_HERR: begin
        case (sub_q)
          3'd0: begin
            ho_re = 1'b1;
            sub_d = 3'd1;
          end
          3'd1: begin
            mul_a = A_W'(ho_w);
            mul_b = B_W'(g_j);
            sub_d = 3'd2;
          end
          3'd2: begin
            acc_d = acc_q + prod_x;
            if (j_last_o) begin
              sub_d = 3'd3;
            end else begin
              j_d   = j_q + 1'b1;
              sub_d = 3'd0;
            end
          end
          3'd3: begin
            tmp_d = B_W'(acc_rnd);
            mul_a = A_W'({1'b0, y_i});
            mul_b = B_W'(17'h10000 - {1'b0, y_i});
            sub_d = 3'd4;
          end
          3'd4: begin
            mul_a = A_W'({1'b0, mul_p[31:16]});
            mul_b = tmp_q;
            sub_d = 3'd5;
          end
          3'd5: begin
            mul_a = A_W'({1'b0, lr_q});
            mul_b = B_W'(mom_v);
            sub_d = 3'd6;
          end
          default: begin
            ch_we = 1'b1;
            acc_d = '0;
            j_d   = '0;
            sub_d = 3'd0;
            if (i_last_h) begin
              i_d     = '0;
              state_d = ST_UO;
            end else begin
              i_d = i_q + 1'b1;
            end
          end
        endcase
      end

      // Output weight update: scaled activation p once per hidden unit,
      // then change, momentum and write-back per weight.
      ST_UO: begin
        case (sub_q)
          3'd0: begin
            mul_a = A_W'({1'b0, lr_q});
            mul_b = B_W'({1'b0, y_i});
            sub_d = 3'd1;
          end
          3'd1: begin
            p_d   = mom_v[15:0];
            j_d   = '0;
            sub_d = 3'd2;
          end
          3'd2: begin
            ho_re = 1'b1;
            mul_a = A_W'({1'b0, p_q});
            mul_b = B_W'(g_j);
            sub_d = 3'd3;
          end
          3'd3: begin
            c_d   = sat16(-((prod_x + RND35) >>> 36));
            mul_a = A_W'({1'b0, mg_q});
            mul_b = B_W'(ho_prev);
            sub_d = 3'd4;
          end
          default: begin
            ho_we    = 1'b1;
            ho_wdata = {sat16(ACC_W'(ho_w) + ACC_W'(c_q) + mom_v), c_q};
            if (j_last_o) begin
              j_d   = '0;
              sub_d = 3'd0;
              if (i_last_h) begin
                i_d     = '0;
                state_d = ST_UI;
              end else begin
                i_d = i_q + 1'b1;
              end
            end else begin
              j_d   = j_q + 1'b1;
              sub_d = 3'd2;
            end
          end
        endcase
      end

      // Input weight update: every weight gets momentum; the change applies
      // only where the input bit is set.
      ST_UI: begin
        case (sub_q)
          3'd0: begin
            ih_re = 1'b1;
            sub_d = 3'd1;
          end
          3'd1: begin
            mul_a = A_W'({1'b0, mg_q});
            mul_b = B_W'(ih_prev);
            sub_d = 3'd2;
          end
          default: begin
            ih_we    = 1'b1;
            ih_wdata = {sat16(ACC_W'(ih_w) + ACC_W'(cx) + mom_v), cx};
            sub_d    = 3'd0;
            if (j_last_h) begin
              j_d = '0;
              if (i_last_in) begin
                i_d     = '0;
                state_d = ST_IDLE;
              end else begin
                i_d = i_q + 1'b1;
              end
            end else begin
              j_d = j_q + 1'b1;
            end
          end
        endcase
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sub_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      res_valid_q <= 1'b0;
      lr_q        <= LR_RESET;
      mg_q        <= MG_RESET;
      ih_vld_q    <= '0;
      ho_vld_q    <= '0;
      ih_vrd_q    <= 1'b0;
      ho_vrd_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      sub_q       <= sub_d;
      i_q         <= i_d;
      j_q         <= j_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_LEARNING_RATE: lr_q <= cfg_wdata_i;
          CFG_MOMENTUM_GAIN: mg_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (ih_we) begin
        ih_vld_q[ih_waddr] <= 1'b1;
      end
      if (ho_we) begin
        ho_vld_q[ho_waddr] <= 1'b1;
      end
      if (ih_re) begin
        ih_vrd_q <= ih_vld_q[ih_raddr];
      end
      if (ho_re) begin
        ho_vrd_q <= ho_vld_q[ho_raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    sumsq_q    <= sumsq_d;
    tmp_q      <= tmp_d;
    p_q        <= p_d;
    c_q        <= c_d;
    pbit_q     <= pbit_d;
    res_unit_q <= res_unit_d;
    res_act_q  <= res_act_d;
    res_err_q  <= res_err_d;
    res_last_q <= res_last_d;
    if (latch_in) begin
      cmd_q      <= cmd_e'(command_i);
      pat_q      <= pat_ext[INPUTS-1:0];
      tgt_q      <= tgt_ext[OUTPUTS-1:0];
      ld_layer_q <= weight_layer_i;
      ld_row_q   <= weight_row_i;
      ld_col_q   <= weight_col_i;
      ld_val_q   <= weight_value_i;
    end
    if (hid_we) begin
      hid_act_q[j_q[HW-1:0]] <= sig_act;
    end
    if (out_we) begin
      out_act_q[j_q[OW-1:0]] <= out_wdata;
      e_q[j_q[OW-1:0]]       <= e_wdata;
    end
    if (g_we) begin
      g_q[j_q[OW-1:0]] <= g_wdata;
    end
    if (ch_we) begin
      ch_q[i_q[HW-1:0]] <= ch_wdata;
    end
  end

  assign result_valid_o  = res_valid_q;
  assign unit_index_o    = res_unit_q;
  assign activation_o    = res_act_q;
  assign pattern_error_o = res_err_q;
  assign last_o          = res_last_q;

endmodule

>>> design/mlpbp_ram.sv
// Generic simple dual-port RAM with registered read data.
module mlpbp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/mlpbp_mul.sv
// Shared signed multiplier with a registered product.
module mlpbp_mul import mlpbp_pkg::*; (
  input  logic                     clk_i,
  input  logic signed [A_W-1:0]    a_i,
  input  logic signed [B_W-1:0]    b_i,
  output logic signed [PROD_W-1:0] p_o
);

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

>>> design/mlpbp_sig.sv
// Sigmoid lookup over a saturated Q4.12 net input, registered output.
module mlpbp_sig import mlpbp_pkg::*; (
  input  logic              clk_i,
  input  w16_t              net_i,
  output logic [ACT_W-1:0]  act_o
);

  localparam sig_tab_t SigTable = build_sig_table();

  logic [ACT_W-1:0] act_q;

  // Index is (net + 32768) >> 6: the offset flips the sign bit.
  always_ff @(posedge clk_i) begin
    act_q <= SigTable[{~net_i[15], net_i[14:6]}];
  end

  assign act_o = act_q;

endmodule
